// ----- rtl/alcp_pkg.sv -----
// shared types, codes and constants of the aging life cache policy unit
package alcp_pkg;

  localparam int unsigned ENTRIES_DEF   = 16;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam logic signed [31:0] LIFE_LIMIT = 32'sd1000;
  localparam logic signed [31:0] LIFE_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] AGE_FLOOR  = 32'sh8000_0001;
  localparam logic [4:0]         CFG_RESET  = 5'd16;

  typedef enum logic [1:0] {
    MODE_OPEN    = 2'd0,
    MODE_INV_ONE = 2'd1,
    MODE_INV_ALL = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_FILLED   = 3'd1,
    ST_FAILED   = 3'd2,
    ST_DISABLED = 3'd3,
    ST_INV_DONE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_UPDATE,
    S_FILL,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic fill;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic skip_scan;
    logic last;
    logic need_fill;
    logic out_busy;
  } stat_t;

endpackage

// ----- rtl/alcp_ram.sv -----
// generic single write port ram with registered read
module alcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/alcp_ctrl.sv -----
// sequencer of the cache policy: accept, scan, fill and deliver
module alcp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  alcp_pkg::stat_t stat,
  output alcp_pkg::cmd_t  cmd
);
  import alcp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_START;
      S_START:  state_next = stat.skip_scan ? S_PUSH : S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: begin
        if (stat.last) begin
          state_next = stat.need_fill ? S_FILL : S_PUSH;
        end else begin
          state_next = S_READ;
        end
      end
      S_FILL:   state_next = S_PUSH;
      S_PUSH:   if (!stat.out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_READ:   cmd.read = 1'b1;
      S_UPDATE: cmd.update = 1'b1;
      S_FILL:   cmd.fill = 1'b1;
      S_PUSH:   cmd.push = !stat.out_busy;
      default: begin
        cmd = '0;
      end
    endcase
  end
endmodule

// ----- rtl/alcp_datapath.sv -----
// entry table, scan arithmetic and result register
module alcp_datapath #(
  parameter int unsigned ENTRIES   = alcp_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_WIDTH = alcp_pkg::KEY_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [4:0]      cfg_data,
  input  logic [1:0]      mode,
  input  logic [31:0]     src_key,
  input  logic [31:0]     style_key,
  input  logic            src_is_file,
  input  logic            open_ok,
  input  logic [31:0]     open_time,
  input  alcp_pkg::cmd_t  cmd,
  output alcp_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      status,
  output logic [3:0]      entry_index,
  output logic            needs_close,
  output logic [4:0]      cleared_count
);
  import alcp_pkg::*;

  localparam int unsigned IW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned RW = 2 + 2 * KEY_WIDTH + 64;

  typedef struct packed {
    logic                 valid;
    logic                 is_file;
    logic [KEY_WIDTH-1:0] src;
    logic [KEY_WIDTH-1:0] style;
    logic signed [31:0]   life;
    logic [31:0]          cost;
  } rec_t;

  logic [4:0]           cfg_reg;
  logic [CW-1:0]        n_act;
  logic [ENTRIES-1:0]   written;
  mode_t                m_mode;
  logic [KEY_WIDTH-1:0] m_src, m_style;
  logic                 m_file, m_ok;
  logic [31:0]          m_time;
  logic [IW-1:0]        idx;
  logic                 hit_found;
  logic [IW-1:0]        hit_idx;
  logic signed [31:0]   min_life;
  logic [IW-1:0]        min_idx;
  logic                 min_valid;
  logic [CW-1:0]        cnt;

  logic [KEY_WIDTH+31:0] src_ext, style_ext;
  logic [RW-1:0]         ram_rdata, ram_wdata;
  logic [IW-1:0]         ram_waddr;
  logic                  ram_we;
  rec_t                  cur, upd_rec, fill_rec;
  logic signed [31:0]    aged;
  logic signed [33:0]    gain_sum;
  logic signed [31:0]    capped;
  logic                  match, take, kill;
  logic [IW+3:0]         hit_ext, min_ext;

  assign src_ext   = {{KEY_WIDTH{1'b0}}, src_key};
  assign style_ext = {{KEY_WIDTH{1'b0}}, style_key};

  // register value above the table size acts as the table size
  always_comb begin
    if (32'(cfg_reg) > ENTRIES) begin
      n_act = CW'(ENTRIES);
    end else begin
      n_act = CW'(cfg_reg);
    end
  end

  alcp_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // never written entries read as all zero
  assign cur = written[idx] ? rec_t'(ram_rdata) : '0;

  assign aged     = (cur.life > AGE_FLOOR) ? cur.life - 32'sd1 : cur.life;
  assign gain_sum = 34'(aged) + $signed({2'b00, cur.cost});
  assign capped   = (gain_sum > 34'(LIFE_LIMIT)) ? LIFE_LIMIT : gain_sum[31:0];
  assign match    = cur.valid && (cur.src == m_src) && (cur.is_file || cur.style == m_style);
  assign take     = match && !hit_found;
  assign kill     = (m_mode == MODE_INV_ALL) || (cur.valid && cur.src == m_src);

  always_comb begin
    upd_rec = cur;
    if (m_mode == MODE_OPEN) begin
      upd_rec.life = take ? capped : aged;
    end else if (kill) begin
      upd_rec = '0;
    end
  end

  always_comb begin
    fill_rec = '0;
    if (m_ok) begin
      fill_rec.valid   = 1'b1;
      fill_rec.is_file = m_file;
      fill_rec.src     = m_src;
      fill_rec.style   = m_style;
      fill_rec.cost    = (m_time == 32'd0) ? 32'd1 : m_time;
    end else begin
      fill_rec.life = LIFE_MIN;
    end
  end

  assign ram_we    = cmd.update || cmd.fill;
  assign ram_waddr = cmd.fill ? min_idx : idx;
  assign ram_wdata = cmd.fill ? RW'(fill_rec) : RW'(upd_rec);

  always_comb begin
    stat.skip_scan = (m_mode == MODE_UNUSED) || (n_act == '0);
    stat.last      = (CW'(idx) + CW'(1)) == n_act;
    stat.need_fill = (m_mode == MODE_OPEN) && !hit_found && !take;
    stat.out_busy  = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= CFG_RESET;
      written <= '0;
    end else begin
      if (cfg_write) begin
        cfg_reg <= cfg_data;
        written <= '0;
      end else if (ram_we) begin
        written[ram_waddr] <= 1'b1;
      end
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      m_mode    <= mode_t'(mode);
      m_src     <= src_ext[KEY_WIDTH-1:0];
      m_style   <= style_ext[KEY_WIDTH-1:0];
      m_file    <= src_is_file;
      m_ok      <= open_ok;
      m_time    <= open_time;
      idx       <= '0;
      hit_found <= 1'b0;
      hit_idx   <= '0;
      cnt       <= '0;
      min_life  <= '0;
      min_idx   <= '0;
      min_valid <= 1'b0;
    end else if (cmd.update) begin
      idx <= idx + IW'(1);
      if (m_mode == MODE_OPEN) begin
        if (take) begin
          hit_found <= 1'b1;
          hit_idx   <= idx;
        end
        if (idx == '0 || aged < min_life) begin
          min_life  <= aged;
          min_idx   <= idx;
          min_valid <= cur.valid;
        end
      end else if (kill && cur.valid) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  assign hit_ext = {4'd0, hit_idx};
  assign min_ext = {4'd0, min_idx};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      entry_index   <= '0;
      needs_close   <= 1'b0;
      cleared_count <= '0;
      if (m_mode == MODE_UNUSED) begin
        status <= ST_INV_DONE;
      end else if (m_mode != MODE_OPEN) begin
        status        <= ST_INV_DONE;
        cleared_count <= 5'({{5{1'b0}}, cnt});
      end else if (n_act == '0) begin
        status <= ST_DISABLED;
      end else if (hit_found) begin
        status      <= ST_HIT;
        entry_index <= hit_ext[3:0];
      end else begin
        status      <= m_ok ? ST_FILLED : ST_FAILED;
        entry_index <= min_ext[3:0];
        needs_close <= min_valid;
      end
    end
  end
endmodule

// ----- rtl/aging_life_cache_policy_unit.sv -----
// top level of the aging life cache policy unit
// usage:
//   requests arrive on the in channel (in_valid / in_ready): an open request
//   carrying the keys and the open outcome, or an invalidate of one source or
//   of all entries. each item gives exactly one result on the out channel
//   (out_valid / out_ready) with status, entry index, close flag and count.
//   the entry table lives in one ram, so an item walks the active entries
//   one at a time: a read state and an update state per entry.
//   sequence: a start state, then the scan, then a fill state to refill a miss
//   victim, then the push; unused mode or a disabled cache skips the scan. one
//   item is in flight at a time; the next item is taken once the result has
//   been pushed to the output register.
//   cfg_write loads entries_in_use and wipes the table; write it only while
//   the unit is idle.
//   reset: entries_in_use returns to 16, the table reads as empty and the
//   result register is empty.
//   stall: a result waits in the output register until taken; a new item may
//   be accepted meanwhile, and its result holds in the sequencer until the
//   output register frees up.
module aging_life_cache_policy_unit #(
  parameter int unsigned ENTRIES   = alcp_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_WIDTH = alcp_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] src_key,
  input  logic [31:0] style_key,
  input  logic        src_is_file,
  input  logic        open_ok,
  input  logic [31:0] open_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  entry_index,
  output logic        needs_close,
  output logic [4:0]  cleared_count
);
  import alcp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  alcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, aging and victim search
  alcp_datapath #(.ENTRIES(ENTRIES), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .src_key       (src_key),
    .style_key     (style_key),
    .src_is_file   (src_is_file),
    .open_ok       (open_ok),
    .open_time     (open_time),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .entry_index   (entry_index),
    .needs_close   (needs_close),
    .cleared_count (cleared_count)
  );
endmodule

// ----- sim/testbench.sv -----
// self-checking testbench of the aging life cache policy unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import alcp_pkg::*;

  localparam int unsigned NENT = ENTRIES_DEF;
  // longest scan plus refill, with some margin
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AT_ITEM = 1300;

  typedef struct {
    mode_t       mode;
    logic [31:0] src;
    logic [31:0] style;
    logic        is_file;
    logic        ok;
    logic [31:0] otime;
  } request_t;

  typedef struct {
    status_t    status;
    logic [3:0] index;
    logic       close;
    logic [4:0] cleared;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [31:0] src_key = '0;
  logic [31:0] style_key = '0;
  logic        src_is_file = 1'b0;
  logic        open_ok = 1'b0;
  logic [31:0] open_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [3:0]  entry_index;
  logic        needs_close;
  logic [4:0]  cleared_count;

  aging_life_cache_policy_unit i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .src_key(src_key),
    .style_key(style_key), .src_is_file(src_is_file), .open_ok(open_ok),
    .open_time(open_time), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .entry_index(entry_index), .needs_close(needs_close),
    .cleared_count(cleared_count)
  );

  always #5 clk = ~clk;

  // predictor copy of the cache table
  logic [4:0]         shadow_in_use;
  logic               shadow_valid [NENT];
  logic               shadow_file [NENT];
  logic [31:0]        shadow_src [NENT];
  logic [31:0]        shadow_style [NENT];
  logic signed [31:0] shadow_life [NENT];
  logic [31:0]        shadow_cost [NENT];

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int unsigned mismatch_count = 0;
  int unsigned accepted_items = 0;

  // key pools keep hits frequent; reshuffled per phase
  logic [31:0] src_pool [8];
  logic [31:0] style_pool [3];

  function automatic void wipe_entry(int unsigned i);
    shadow_valid[i] = 1'b0;
    shadow_file[i]  = 1'b0;
    shadow_src[i]   = '0;
    shadow_style[i] = '0;
    shadow_life[i]  = '0;
    shadow_cost[i]  = '0;
  endfunction

  function automatic void wipe_table();
    for (int unsigned i = 0; i < NENT; i++) wipe_entry(i);
  endfunction

  // computes the outcome of one request and updates the shadow table
  function automatic outcome_t predict_lookup(request_t r);
    outcome_t    o;
    int unsigned n;
    int unsigned victim;
    int unsigned cnt;
    longint      grown;
    bit          match;
    n = (shadow_in_use > NENT) ? NENT : shadow_in_use;
    o.status = ST_INV_DONE;
    o.index = '0;
    o.close = 1'b0;
    o.cleared = '0;
    if (r.mode == MODE_INV_ONE || r.mode == MODE_INV_ALL) begin
      cnt = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (r.mode == MODE_INV_ALL || (shadow_valid[i] && shadow_src[i] == r.src)) begin
          if (shadow_valid[i]) cnt++;
          wipe_entry(i);
        end
      end
      o.cleared = cnt[4:0];
      return o;
    end
    if (r.mode == MODE_UNUSED) return o;
    if (n == 0) begin
      o.status = ST_DISABLED;
      return o;
    end
    // aging stops one above the floor
    for (int unsigned i = 0; i < n; i++)
      if (shadow_life[i] > AGE_FLOOR) shadow_life[i] = shadow_life[i] - 1;
    for (int unsigned i = 0; i < n; i++) begin
      match = shadow_valid[i] && shadow_src[i] == r.src &&
              (shadow_file[i] || shadow_style[i] == r.style);
      if (match) begin
        grown = longint'(shadow_life[i]) + longint'({32'd0, shadow_cost[i]});
        if (grown > 1000) grown = 1000;
        shadow_life[i] = grown[31:0];
        o.status = ST_HIT;
        o.index = i[3:0];
        return o;
      end
    end
    victim = 0;
    for (int unsigned i = 1; i < n; i++)
      if (shadow_life[i] < shadow_life[victim]) victim = i;
    o.index = victim[3:0];
    o.close = shadow_valid[victim];
    if (!r.ok) begin
      wipe_entry(victim);
      shadow_life[victim] = LIFE_MIN;
      o.status = ST_FAILED;
    end else begin
      shadow_valid[victim] = 1'b1;
      shadow_file[victim]  = r.is_file;
      shadow_src[victim]   = r.src;
      shadow_style[victim] = r.style;
      shadow_life[victim]  = '0;
      shadow_cost[victim]  = (r.otime == 0) ? 32'd1 : r.otime;
      o.status = ST_FILLED;
    end
    return o;
  endfunction

  function automatic request_t build_request(mode_t m, logic [31:0] s, logic [31:0] st,
                                             logic f, logic ok, logic [31:0] t);
    request_t r;
    r.mode = m;
    r.src = s;
    r.style = st;
    r.is_file = f;
    r.ok = ok;
    r.otime = t;
    return r;
  endfunction

  function automatic void shuffle_pools();
    for (int i = 0; i < 8; i++) src_pool[i] = $urandom;
    for (int i = 0; i < 3; i++) style_pool[i] = $urandom;
    src_pool[0] = '0;
    src_pool[1] = '1;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) r.mode = MODE_OPEN;
    else if (pick < 87) r.mode = MODE_INV_ONE;
    else if (pick < 95) r.mode = MODE_INV_ALL;
    else r.mode = MODE_UNUSED;
    r.src = ($urandom_range(9) == 0) ? $urandom : src_pool[$urandom_range(7)];
    r.style = ($urandom_range(9) == 0) ? $urandom : style_pool[$urandom_range(2)];
    r.is_file = $urandom_range(1);
    r.ok = ($urandom_range(99) < 85);
    pick = $urandom_range(9);
    if (pick < 4) r.otime = $urandom_range(20);
    else if (pick < 7) r.otime = $urandom_range(2000);
    else if (pick == 7) r.otime = '0;
    else if (pick == 8) r.otime = $urandom;
    else r.otime = '1;
    return r;
  endfunction

  // sender: bursts of items separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    request_t cur;
    logic     next_valid;
    next_valid = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        cur = build_request(mode_t'(mode), src_key, style_key, src_is_file, open_ok,
                            open_time);
        expected_outcomes.push_back(predict_lookup(cur));
        accepted_items <= accepted_items + 1;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() > 0) begin
          cur = pending_requests.pop_front();
          mode <= cur.mode;
          src_key <= cur.src;
          style_key <= cur.style;
          src_is_file <= cur.is_file;
          open_ok <= cur.ok;
          open_time <= cur.otime;
          next_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(30, 1);
            // some bursts run back to back
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  // receiver: random stall patterns, one long hold-off
  int unsigned stall_style = 0;
  int unsigned pattern_cycle = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    pattern_cycle <= pattern_cycle + 1;
    if (pattern_cycle % 64 == 0) stall_style <= $urandom_range(3);
    if (!hold_done && accepted_items >= HOLD_AT_ITEM) begin
      // input keeps offering items while results back up
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (stall_style)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(1);
        2: out_ready <= ($urandom_range(3) == 0);
        default: out_ready <= ($urandom_range(7) != 0);
      endcase
    end
  end

  // monitor: compare every result with the oldest prediction
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && out_valid && out_ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no item outstanding: status %0d", status);
        mismatch_count = mismatch_count + 1;
      end else begin
        exp_o = expected_outcomes.pop_front();
        if (status !== exp_o.status) begin
          $error("status expected %0d actual %0d", exp_o.status, status);
          mismatch_count = mismatch_count + 1;
        end
        if (entry_index !== exp_o.index) begin
          $error("entry_index expected %0d actual %0d", exp_o.index, entry_index);
          mismatch_count = mismatch_count + 1;
        end
        if (needs_close !== exp_o.close) begin
          $error("needs_close expected %0d actual %0d", exp_o.close, needs_close);
          mismatch_count = mismatch_count + 1;
        end
        if (cleared_count !== exp_o.cleared) begin
          $error("cleared_count expected %0d actual %0d", exp_o.cleared, cleared_count);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // wait until the unit holds nothing, then a scan's worth more
  task automatic drain_unit();
    while (pending_requests.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_entries(logic [4:0] count);
    drain_unit();
    cfg_write <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_in_use = count;
    wipe_table();
    shuffle_pools();
  endtask

  task automatic queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) pending_requests.push_back(random_request());
  endtask

  initial begin
    shadow_in_use = CFG_RESET;
    wipe_table();
    shuffle_pools();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full table
    set_entries(5'd16);
    // memory miss with extreme keys, then a hit on both keys
    pending_requests.push_back(build_request(MODE_OPEN, '1, '1, 1'b0, 1'b1, 32'd5));
    pending_requests.push_back(build_request(MODE_OPEN, '1, '1, 1'b0, 1'b1, 32'd0));
    // same source with another style misses for a memory entry
    pending_requests.push_back(build_request(MODE_OPEN, '1, '0, 1'b0, 1'b1, 32'd0));
    // file entry hits on source key alone
    pending_requests.push_back(build_request(MODE_OPEN, '0, 32'h5a5a_a5a5, 1'b1, 1'b1,
                                             '1));
    pending_requests.push_back(build_request(MODE_OPEN, '0, 32'h1234_5678, 1'b0, 1'b0,
                                             '0));
    // huge cost caps life at the limit
    pending_requests.push_back(build_request(MODE_OPEN, '0, '0, 1'b1, 1'b1, '0));
    // failed open sends the victim to the floor
    pending_requests.push_back(build_request(MODE_OPEN, 32'h0000_00aa, '0, 1'b0, 1'b0,
                                             32'd7));
    pending_requests.push_back(build_request(MODE_OPEN, 32'h0000_00ab, '0, 1'b0, 1'b0,
                                             32'd7));
    for (int i = 0; i < 15; i++)
      pending_requests.push_back(build_request(MODE_OPEN, 32'h100 + i, '1, i[0], 1'b1,
                                               i));
    pending_requests.push_back(build_request(MODE_INV_ONE, '1, '0, 1'b0, 1'b0, '0));
    pending_requests.push_back(build_request(MODE_UNUSED, '1, '1, 1'b1, 1'b1, '1));
    pending_requests.push_back(build_request(MODE_INV_ALL, '0, '0, 1'b0, 1'b0, '0));

    // disabled cache
    set_entries(5'd0);
    pending_requests.push_back(build_request(MODE_OPEN, '1, '1, 1'b1, 1'b1, '1));
    pending_requests.push_back(build_request(MODE_INV_ALL, '0, '0, 1'b0, 1'b0, '0));
    queue_random(50);
    // single entry
    set_entries(5'd1);
    queue_random(150);
    // above the table size acts as a full table
    set_entries(5'd31);
    queue_random(350);
    set_entries(5'd5);
    queue_random(300);
    // long run with the receiver hold-off
    set_entries(5'd16);
    queue_random(900);

    drain_unit();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- aging_life_cache_policy_unit.f -----
rtl/alcp_pkg.sv
rtl/alcp_ram.sv
rtl/alcp_ctrl.sv
rtl/alcp_datapath.sv
rtl/aging_life_cache_policy_unit.sv
sim/testbench.sv
